FILE: hw/rtl/bmsi_pkg.sv
`default_nettype none
package bmsi_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_LOW   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_COPIES   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ASSERT_DELAY = 3'd4;

  localparam logic [3:0] GRP_PRG0  = 4'h8;
  localparam logic [3:0] GRP_MISC  = 4'h9;
  localparam logic [3:0] GRP_PRG1  = 4'hA;
  localparam logic [3:0] GRP_CHR_B = 4'hB;
  localparam logic [3:0] GRP_CHR_C = 4'hC;
  localparam logic [3:0] GRP_CHR_D = 4'hD;
  localparam logic [3:0] GRP_CHR_E = 4'hE;
  localparam logic [3:0] GRP_IRQ   = 4'hF;

  localparam logic [1:0] SEL_0 = 2'd0;
  localparam logic [1:0] SEL_1 = 2'd1;
  localparam logic [1:0] SEL_2 = 2'd2;
  localparam logic [1:0] SEL_3 = 2'd3;

  localparam logic [1:0] SLOT_REG0  = 2'd0;
  localparam logic [1:0] SLOT_REG1  = 2'd1;
  localparam logic [1:0] SLOT_FIXED = 2'd2;
  localparam logic [1:0] SLOT_LAST  = 2'd3;

  localparam logic [7:0] PRG_FIXED_BANK = 8'hFE;
  localparam logic [7:0] PRG_LAST_BANK  = 8'hFF;

  localparam logic [9:0] PRESCALE_PERIOD = 10'd341;
  localparam logic [9:0] PRESCALE_STEP   = 10'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [12:0] ppu_address;
  } in_item_t;

  typedef struct packed {
    logic        irq_asserted;
    logic [7:0]  prg_bank;
    logic [11:0] chr_bank;
    logic [1:0]  mirror_mode;
    logic        wram_mapped;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bank_mapper_with_scanline_irq.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | in_data (in_item_t)
// out     | output    | out_valid/out_ready | out_data (out_item_t)
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// Each transfer on in updates the mapper state and loads its result into the
// output register at the same edge, so the result appears in the cycle after the transfer.
// One item is taken every cycle unless the sink stalls; the single output register sets the rate.
// in_ready drops only while a result waits in that register and out_ready is low.
// Synchronous active-low reset restores all banks, the IRQ unit and the
// configuration registers to their documented values.
`default_nettype none
module bank_mapper_with_scanline_irq
  import bmsi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic        second_mode_r;
  logic [11:0] select_low_r;
  logic [11:0] select_high_r;
  logic        ack_copies_r;
  logic [7:0]  assert_delay_r;

  logic [7:0]  prg_regs_r [2];
  logic [11:0] chr_regs_r [8];
  logic [1:0]  mirror_r;
  logic        wram_enable_r;
  logic        prg_swap_r;
  logic [2:0]  irq_control_r;
  logic [7:0]  irq_counter_r;
  logic [7:0]  irq_reload_r;
  logic [9:0]  prescaler_r;
  logic [7:0]  countdown_r;
  logic        irq_line_r;

  logic [7:0]  prg_regs_nxt [2];
  logic [11:0] chr_regs_nxt [8];
  logic [1:0]  mirror_nxt;
  logic        wram_enable_nxt;
  logic        prg_swap_nxt;
  logic [2:0]  irq_control_nxt;
  logic [7:0]  irq_counter_nxt;
  logic [7:0]  irq_reload_nxt;
  logic [9:0]  prescaler_nxt;
  logic [7:0]  countdown_nxt;
  logic        irq_line_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   result;

  logic        accept;
  logic [3:0]  grp;
  logic [1:0]  sel;
  logic [1:0]  sel_misc;
  logic [1:0]  grp_off;
  logic [2:0]  chr_idx;
  logic [10:0] pre_dec;
  logic [10:0] pre_wrap;
  logic        pre_fire;
  logic        cnt_fire;
  logic [7:0]  cnt_inc;
  logic [7:0]  cd_dec;
  logic [1:0]  slot;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign grp      = in_data.cpu_address[15:12];
  assign sel      = {|(in_data.cpu_address[11:0] & select_high_r),
                     |(in_data.cpu_address[11:0] & select_low_r)};
  assign sel_misc = second_mode_r ? sel : SEL_0;
  assign grp_off  = 2'(grp - GRP_CHR_B);
  assign chr_idx  = {grp_off, sel[1]};

  assign pre_dec  = {1'b0, prescaler_r} - {1'b0, PRESCALE_STEP};
  assign pre_wrap = pre_dec + {1'b0, PRESCALE_PERIOD};
  assign pre_fire = pre_dec[10] || (pre_dec == 11'd0);
  assign cnt_fire = irq_control_r[2] || pre_fire;
  assign cnt_inc  = irq_counter_r + 8'd1;
  assign cd_dec   = countdown_r - 8'd1;

  always_comb begin
    prg_regs_nxt    = prg_regs_r;
    chr_regs_nxt    = chr_regs_r;
    mirror_nxt      = mirror_r;
    wram_enable_nxt = wram_enable_r;
    prg_swap_nxt    = prg_swap_r;
    irq_control_nxt = irq_control_r;
    irq_counter_nxt = irq_counter_r;
    irq_reload_nxt  = irq_reload_r;
    prescaler_nxt   = prescaler_r;
    countdown_nxt   = countdown_r;
    irq_line_nxt    = irq_line_r;

    case (in_data.opcode)
      OP_WRITE: begin
        case (grp) inside
          GRP_PRG0: prg_regs_nxt[0] = in_data.write_data;
          GRP_PRG1: prg_regs_nxt[1] = in_data.write_data;
          GRP_MISC: begin
            case (sel_misc) inside
              SEL_0, SEL_1: mirror_nxt = in_data.write_data[1:0];
              SEL_2: begin
                wram_enable_nxt = in_data.write_data[0];
                prg_swap_nxt    = in_data.write_data[1];
              end
              default: ;
            endcase
          end
          GRP_CHR_B, GRP_CHR_C, GRP_CHR_D, GRP_CHR_E: begin
            if (sel[0]) begin
              chr_regs_nxt[chr_idx] = {in_data.write_data, chr_regs_r[chr_idx][3:0]};
            end else begin
              chr_regs_nxt[chr_idx] = {chr_regs_r[chr_idx][11:4], in_data.write_data[3:0]};
            end
          end
          GRP_IRQ: begin
            if (second_mode_r) begin
              case (sel)
                SEL_0: irq_reload_nxt = {irq_reload_r[7:4], in_data.write_data[3:0]};
                SEL_1: irq_reload_nxt = {in_data.write_data[3:0], irq_reload_r[3:0]};
                SEL_2: begin
                  irq_control_nxt = in_data.write_data[2:0];
                  if (in_data.write_data[1]) begin
                    irq_counter_nxt = irq_reload_r;
                    prescaler_nxt   = PRESCALE_PERIOD;
                  end
                  irq_line_nxt = 1'b0;
                end
                default: begin
                  if (ack_copies_r) begin
                    irq_control_nxt = {irq_control_r[2], irq_control_r[0], irq_control_r[0]};
                  end
                  irq_line_nxt = 1'b0;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (countdown_r != 8'd0) begin
          countdown_nxt = cd_dec;
          if (cd_dec == 8'd0) begin
            irq_line_nxt = 1'b1;
          end
        end
        if (irq_control_r[1]) begin
          if (!irq_control_r[2]) begin
            prescaler_nxt = pre_fire ? pre_wrap[9:0] : pre_dec[9:0];
          end
          if (cnt_fire) begin
            irq_counter_nxt = cnt_inc;
            if (cnt_inc == 8'd0) begin
              irq_counter_nxt = irq_reload_r;
              countdown_nxt   = assert_delay_r;
              if (assert_delay_r == 8'd0) begin
                irq_line_nxt = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    slot = in_data.cpu_address[14:13];
    if (prg_swap_nxt && !slot[0]) begin
      slot = slot ^ 2'b10;
    end
    result              = '0;
    result.irq_asserted = irq_line_nxt;
    if (in_data.cpu_address[15]) begin
      case (slot)
        SLOT_REG0:  result.prg_bank = prg_regs_nxt[0];
        SLOT_REG1:  result.prg_bank = prg_regs_nxt[1];
        SLOT_FIXED: result.prg_bank = PRG_FIXED_BANK;
        default:    result.prg_bank = PRG_LAST_BANK;
      endcase
    end
    result.chr_bank    = chr_regs_nxt[in_data.ppu_address[12:10]];
    result.mirror_mode = mirror_nxt & {second_mode_r, 1'b1};
    result.wram_mapped = wram_enable_nxt || !second_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_mode_r  <= 1'b1;
      select_low_r   <= 12'd1;
      select_high_r  <= 12'd2;
      ack_copies_r   <= 1'b1;
      assert_delay_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECOND_MODE:  second_mode_r  <= cfg_wdata[0];
        CFG_SELECT_LOW:   select_low_r   <= cfg_wdata;
        CFG_SELECT_HIGH:  select_high_r  <= cfg_wdata;
        CFG_ACK_COPIES:   ack_copies_r   <= cfg_wdata[0];
        CFG_ASSERT_DELAY: assert_delay_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_regs_r[0] <= 8'd0;
      prg_regs_r[1] <= 8'd1;
      for (int i = 0; i < 8; i++) begin
        chr_regs_r[i] <= 12'(i);
      end
      mirror_r      <= 2'd0;
      wram_enable_r <= 1'b1;
      prg_swap_r    <= 1'b0;
      irq_control_r <= 3'd0;
      irq_counter_r <= 8'd0;
      irq_reload_r  <= 8'd0;
      prescaler_r   <= 10'd0;
      countdown_r   <= 8'd0;
      irq_line_r    <= 1'b0;
    end else if (accept) begin
      prg_regs_r    <= prg_regs_nxt;
      chr_regs_r    <= chr_regs_nxt;
      mirror_r      <= mirror_nxt;
      wram_enable_r <= wram_enable_nxt;
      prg_swap_r    <= prg_swap_nxt;
      irq_control_r <= irq_control_nxt;
      irq_counter_r <= irq_counter_nxt;
      irq_reload_r  <= irq_reload_nxt;
      prescaler_r   <= prescaler_nxt;
      countdown_r   <= countdown_nxt;
      irq_line_r    <= irq_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bmsi_checker.sv
`default_nettype none
module bmsi_checker
  import bmsi_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A result held back by the sink must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transfer produced no result");

  a_prg_outside_rom: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.cpu_address[15] |=> out_data.prg_bank == 8'd0)
    else $error("program bank reported outside the ROM window");

  a_prg_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cpu_address[15:13] == 3'b111)
    |=> out_data.prg_bank == PRG_LAST_BANK)
    else $error("top program slot is not the last bank");

endmodule

bind bank_mapper_with_scanline_irq bmsi_checker u_bmsi_checker (.*);
`default_nettype wire
